FILE: hw/rtl/rdc_pkg.sv
// Package for the radix digit converter: sizes, reset values, register
// indexes, state encoding and the divider status type. No dependencies.
package rdc_pkg;

  localparam int VALUE_W        = 64;
  localparam int VALUE_BITS     = 64;
  localparam int TABLE_SIZE     = 56;
  localparam int NUM_DIGIT_REGS = 7;
  localparam int MAX_DIGITS     = 64;
  localparam int BASE_W         = 6;
  localparam int CHAR_W         = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int DCNT_W         = $clog2(MAX_DIGITS + 1);
  localparam int BITCNT_W       = $clog2(VALUE_W);

  localparam logic [VALUE_W-1:0] VALUE_MASK =
    (VALUE_BITS >= VALUE_W) ? {VALUE_W{1'b1}}
                            : ((VALUE_W'(1) << VALUE_BITS) - VALUE_W'(1));

  localparam logic [BASE_W-1:0]  MIN_BASE   = BASE_W'(2);
  localparam logic [BASE_W-1:0]  BASE_RESET = BASE_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0]  CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;

  localparam logic [63:0] DIGITS0_RESET = 64'h3736_3534_3332_3130;
  localparam logic [63:0] DIGITS1_RESET = 64'h0000_0000_0000_3938;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX       = 3'd0,
    CFG_DIGITS_0_7  = 3'd1,
    CFG_DIGITS_8_15 = 3'd2,
    CFG_DIGITS_16   = 3'd3,
    CFG_DIGITS_24   = 3'd4,
    CFG_DIGITS_32   = 3'd5,
    CFG_DIGITS_40   = 3'd6,
    CFG_DIGITS_48   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              done;
    logic [BASE_W-1:0] rem;
  } div_stat_t;

endpackage

FILE: hw/rtl/rdc_in_if.sv
// Input channel of the radix digit converter: one value per item.
// Depends on rdc_pkg.
interface rdc_in_if import rdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: hw/rtl/rdc_out_if.sv
// Result channel of the radix digit converter: one digit character per item.
// Depends on rdc_pkg.
interface rdc_out_if import rdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

FILE: hw/rtl/rdc_cfg_if.sv
// Configuration write channel of the radix digit converter.
// Depends on rdc_pkg.
interface rdc_cfg_if import rdc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/rdc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle. Depends on rdc_pkg.
module rdc_div import rdc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  input  logic [BASE_W-1:0]  divisor,
  output div_stat_t          stat,
  output logic [VALUE_W-1:0] quot
);

  logic [VALUE_W-1:0]  quo_r;
  logic [BASE_W-1:0]   rem_r;
  logic [BITCNT_W-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [BASE_W:0]     trial;
  logic                ge;

  // The partial remainder stays below the divisor, so one extra bit is enough.
  assign trial = {rem_r, quo_r[VALUE_W-1]};
  assign ge    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + BITCNT_W'(1);
        if (cnt_r == BITCNT_W'(VALUE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[VALUE_W-2:0], ge};
      rem_r <= ge ? BASE_W'(trial - {1'b0, divisor}) : trial[BASE_W-1:0];
    end
  end

  assign stat.done = done_r;
  assign stat.rem  = rem_r;
  assign quot      = quo_r;

endmodule

FILE: hw/rtl/radix_digit_converter_core.sv
// Radix digit converter: writes an unsigned value in a configured base,
// most significant digit first. Depends on rdc_pkg, the channel interfaces
// and rdc_div.
//
// Usage: write the radix (index 0) and the digit table (indexes 1 to 7) over
// cfg_ch while the block is idle; writes are always taken. Each value item on
// in_ch is first checked against the table: the radix must lie in 2..56 and
// every entry in use must be nonzero, not '+' or '-', and unique. A table that
// fails yields no result item at all. The check compares one pair of entries
// per cycle. The digits then come from repeated division by the radix in a
// bit-serial divider, and the first result of an item follows the last of
// its divisions. Results leave on out_ch one digit per cycle, with last_digit
// set on the final one, through an output register; a stalled receiver holds
// the current result and pauses the block. in_ch is ready again once the
// last result is loaded into the output register.
// Reset restores radix ten with the table "0123456789" and drops any item.
module radix_digit_converter_core import rdc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rdc_in_if.sink    in_ch,
  rdc_out_if.source out_ch,
  rdc_cfg_if.sink   cfg_ch
);

  logic [BASE_W-1:0]                   radix_r;
  logic [NUM_DIGIT_REGS-1:0][63:0]     digit_regs_r;
  logic [TABLE_SIZE*CHAR_W-1:0]        tbl_flat;

  state_t                              state_r, state_nxt;
  logic [VALUE_W-1:0]                  value_r;
  logic [BASE_W-1:0]                   scan_r;
  logic [BASE_W-1:0]                   pair_r;
  logic [MAX_DIGITS-1:0][BASE_W-1:0]   stk_r;
  logic [DCNT_W-1:0]                   dcnt_r;
  logic                                out_valid_r;
  logic [CHAR_W-1:0]                   out_char_r;
  logic                                out_last_r;

  logic                                accept;
  logic                                base_ok;
  logic [BASE_W-1:0]                   tbl_idx;
  logic [CHAR_W-1:0]                   chr;
  logic [CHAR_W-1:0]                   chr_pair;
  logic                                at_self;
  logic                                chr_bad;
  logic                                slot_free;
  logic                                div_start;
  logic [VALUE_W-1:0]                  dividend;
  div_stat_t                           div_stat;
  logic [VALUE_W-1:0]                  div_quot;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r      <= BASE_RESET;
      digit_regs_r <= {{(NUM_DIGIT_REGS - 2){64'h0}}, DIGITS1_RESET, DIGITS0_RESET};
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_RADIX: radix_r <= cfg_ch.data[BASE_W-1:0];
        default:   digit_regs_r[cfg_ch.index - CFG_IDX_W'(1)] <= cfg_ch.data;
      endcase
    end
  end

  // Main table read port, shared by the check scan and the digit output, and
  // a second port for the earlier entry that the check compares against.
  assign tbl_flat = digit_regs_r;
  assign tbl_idx  = (state_r == ST_EMIT) ? stk_r[0] : scan_r;

  always_comb begin
    chr = CHAR_NUL;
    if (tbl_idx < BASE_W'(TABLE_SIZE)) begin
      chr = tbl_flat[tbl_idx*CHAR_W +: CHAR_W];
    end
  end

  always_comb begin
    chr_pair = CHAR_NUL;
    if (pair_r < BASE_W'(TABLE_SIZE)) begin
      chr_pair = tbl_flat[pair_r*CHAR_W +: CHAR_W];
    end
  end

  // Entry scan_r is compared with every earlier entry in turn; when the pair
  // index reaches the entry itself, the entry is tested for illegal characters.
  assign accept    = in_ch.valid && in_ch.ready;
  assign base_ok   = (radix_r >= MIN_BASE) && (radix_r <= BASE_W'(TABLE_SIZE));
  assign at_self   = (pair_r == scan_r);
  assign chr_bad   = at_self ? ((chr == CHAR_NUL) || (chr == CHAR_PLUS) ||
                                (chr == CHAR_MINUS))
                             : (chr_pair == chr);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign dividend  = (state_r == ST_CHECK) ? value_r : div_quot;

  rdc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (radix_r),
    .stat     (div_stat),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && base_ok) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chr_bad) begin
          state_nxt = ST_IDLE;
        end else if (at_self && (scan_r == radix_r - BASE_W'(1))) begin
          state_nxt = ST_DIV;
          div_start = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if ((div_quot == '0) || (dcnt_r == DCNT_W'(MAX_DIGITS - 1))) begin
            state_nxt = ST_EMIT;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free && (dcnt_r == DCNT_W'(1))) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // Control counters and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= '0;
      pair_r      <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        scan_r <= '0;
        pair_r <= '0;
        dcnt_r <= '0;
      end else if (state_r == ST_CHECK && !chr_bad) begin
        if (at_self) begin
          scan_r <= scan_r + BASE_W'(1);
          pair_r <= '0;
        end else begin
          pair_r <= pair_r + BASE_W'(1);
        end
      end else if (state_r == ST_DIV && div_stat.done) begin
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end else if (state_r == ST_EMIT && slot_free) begin
        dcnt_r <= dcnt_r - DCNT_W'(1);
      end

      if (state_r == ST_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: the value register, the digit stack and the result payload.
  // Remainders are pushed least significant first and popped in reverse.
  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= in_ch.value & VALUE_MASK;
    end

    if (state_r == ST_DIV && div_stat.done) begin
      stk_r <= {stk_r[MAX_DIGITS-2:0], div_stat.rem};
    end else if (state_r == ST_EMIT && slot_free) begin
      stk_r      <= {BASE_W'(0), stk_r[MAX_DIGITS-1:1]};
      out_char_r <= chr;
      out_last_r <= (dcnt_r == DCNT_W'(1));
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.digit_char = out_char_r;
  assign out_ch.last_digit = out_last_r;

endmodule
